// ===== design/tns_pkg.sv =====
// shared types and constants for the tilemap nibble stamp block
`default_nettype none
package tns_pkg;

    // map geometry
    localparam int MAP_WORDS = 2048;
    localparam int ROW_WORDS = 32;
    localparam int ADDR_W    = $clog2(MAP_WORDS);
    localparam int COL_W     = $clog2(ROW_WORDS);
    localparam int MAX_W     = 64;
    localparam int MAX_H     = 32;

    // configuration port
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 7;

    localparam logic [CFG_IDX_W-1:0] REG_ORIGIN_X    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_ORIGIN_Y    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_RECT_WIDTH  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_RECT_HEIGHT = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_ID_SOURCE   = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_FIXED_ID    = 3'd5;

    // command codes
    typedef enum logic [1:0] {
        CMD_LOAD  = 2'd0,
        CMD_READ  = 2'd1,
        CMD_STAMP = 2'd2
    } t_cmd;

    // input beat
    typedef struct packed {
        logic [1:0]        cmd;
        logic [ADDR_W-1:0] map_addr;
        logic [15:0]       map_data;
        logic [7:0]        blob_byte;
    } t_in;

    // result beat
    typedef struct packed {
        logic [15:0]       read_data;
        logic              wrote;
        logic [ADDR_W-1:0] write_addr;
        logic [7:0]        echo_id;
        logic              blob_done;
        logic              out_of_range;
    } t_out;

    // rectangle geometry handed to the walker
    typedef struct packed {
        logic [5:0] origin_x;
        logic [4:0] origin_y;
        logic [6:0] rect_width;
        logic [5:0] rect_height;
    } t_geom;

    // current cell of the walk
    typedef struct packed {
        logic [ADDR_W-1:0] addr;
        logic              oor;
        logic              done;
    } t_cell;

endpackage
`default_nettype wire

// ===== design/tns_walk.sv =====
// rectangle walker: column and row counters and map address of the current cell
`default_nettype none
module tns_walk (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire tns_pkg::t_geom i_geom,
    input  wire logic          i_restart,
    input  wire logic          i_step,
    output tns_pkg::t_cell     o_cell
);
    import tns_pkg::*;

    logic [5:0] r_col, n_col;
    logic [4:0] r_row, n_row;

    logic [6:0] w_eff;
    logic [5:0] h_eff;
    logic [6:0] col_map;
    logic [5:0] row_map;
    logic       col_last;
    logic       row_last;

    // clamp degenerate sizes
    always_comb begin
        if (i_geom.rect_width == 7'd0) begin
            w_eff = 7'd1;
        end else if (i_geom.rect_width > 7'(MAX_W)) begin
            w_eff = 7'(MAX_W);
        end else begin
            w_eff = i_geom.rect_width;
        end
        if (i_geom.rect_height == 6'd0) begin
            h_eff = 6'd1;
        end else if (i_geom.rect_height > 6'(MAX_H)) begin
            h_eff = 6'(MAX_H);
        end else begin
            h_eff = i_geom.rect_height;
        end
    end

    // map position, screen block select from column bit 5
    always_comb begin
        col_map  = {1'b0, i_geom.origin_x} + {1'b0, r_col};
        row_map  = {1'b0, i_geom.origin_y} + {1'b0, r_row};
        col_last = ({1'b0, r_col} + 7'd1) >= w_eff;
        row_last = ({1'b0, r_row} + 6'd1) >= h_eff;

        o_cell.oor  = col_map[6] | row_map[5];
        o_cell.addr = o_cell.oor ? '0 : {col_map[5], row_map[4:0], col_map[COL_W-1:0]};
        o_cell.done = col_last & row_last;
    end

    // counter advance
    always_comb begin
        n_col = r_col;
        n_row = r_row;
        if (i_restart) begin
            n_col = '0;
            n_row = '0;
        end else if (i_step) begin
            if (col_last) begin
                n_col = '0;
                n_row = row_last ? 5'd0 : r_row + 5'd1;
            end else begin
                n_col = r_col + 6'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col <= '0;
            r_row <= '0;
        end else begin
            r_col <= n_col;
            r_row <= n_row;
        end
    end

endmodule
`default_nettype wire

// ===== design/tilemap_nibble_stamp.sv =====
// top level: tilemap memory with load, read and nibble stamp commands
//
//  channel  | handshake            | payload        | direction
//  ---------+----------------------+----------------+----------
//  command  | start, busy          | i_in  (t_in)   | in
//  result   | o_res_vld            | o_res (t_out)  | out
//  config   | i_cfg_we             | i_cfg_idx/data | in
//
// one beat per cycle; each beat passes the stage one registers, then the result register
// stage one reads the map port, stage two modifies, writes back and registers the result
// a write in stage two to the entry stage one reads is forwarded
// busy stays low; the receiver cannot stall, so nothing backs up
// reset clears config and the walk; map contents stay undefined until loaded
`default_nettype none
module tilemap_nibble_stamp (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire logic                         start,
    output logic                              busy,
    input  wire tns_pkg::t_in                 i_in,
    output logic                              o_res_vld,
    output tns_pkg::t_out                     o_res,
    input  wire logic                         i_cfg_we,
    input  wire logic [tns_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  wire logic [tns_pkg::CFG_DATA_W-1:0] i_cfg_data
);
    import tns_pkg::*;

    // configuration registers
    t_geom      r_geom;
    logic       r_id_src;
    logic [3:0] r_fixed_id;
    logic       cfg_hit;

    always_comb begin
        unique case (i_cfg_idx)
            REG_ORIGIN_X, REG_ORIGIN_Y, REG_RECT_WIDTH,
            REG_RECT_HEIGHT, REG_ID_SOURCE, REG_FIXED_ID: cfg_hit = i_cfg_we;
            default:                                      cfg_hit = 1'b0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_geom.origin_x    <= '0;
            r_geom.origin_y    <= '0;
            r_geom.rect_width  <= 7'd1;
            r_geom.rect_height <= 6'd1;
            r_id_src           <= 1'b0;
            r_fixed_id         <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                REG_ORIGIN_X:    r_geom.origin_x    <= i_cfg_data[5:0];
                REG_ORIGIN_Y:    r_geom.origin_y    <= i_cfg_data[4:0];
                REG_RECT_WIDTH:  r_geom.rect_width  <= i_cfg_data[6:0];
                REG_RECT_HEIGHT: r_geom.rect_height <= i_cfg_data[5:0];
                REG_ID_SOURCE:   r_id_src           <= i_cfg_data[0];
                REG_FIXED_ID:    r_fixed_id         <= i_cfg_data[3:0];
                default: ;
            endcase
        end
    end

    // accept and walk
    logic  acc;
    logic  acc_stamp;
    t_cell cur_cell;

    assign busy      = 1'b0;
    assign acc       = start & ~busy;
    assign acc_stamp = acc & (t_cmd'(i_in.cmd) == CMD_STAMP);

    tns_walk u_walk (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_geom    (r_geom),
        .i_restart (cfg_hit),
        .i_step    (acc_stamp),
        .o_cell    (cur_cell)
    );

    // stage one: read port and captured beat
    logic [ADDR_W-1:0] rd_addr;
    logic              r_s1_vld;
    logic [1:0]        r_s1_cmd;
    logic [ADDR_W-1:0] r_s1_addr;
    logic [15:0]       r_s1_data;
    logic [7:0]        r_s1_byte;
    logic              r_s1_oor;
    logic              r_s1_done;
    logic              r_s1_fwd;
    logic [15:0]       r_s1_fwd_data;

    // stage two write port
    logic              wr_en;
    logic [ADDR_W-1:0] wr_addr;
    logic [15:0]       wr_data;

    assign rd_addr = (t_cmd'(i_in.cmd) == CMD_STAMP) ? cur_cell.addr : i_in.map_addr;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld <= 1'b0;
        end else begin
            r_s1_vld <= acc;
        end
    end

    always_ff @(posedge i_clk) begin
        if (acc) begin
            r_s1_cmd      <= i_in.cmd;
            r_s1_addr     <= rd_addr;
            r_s1_data     <= i_in.map_data;
            r_s1_byte     <= i_in.blob_byte;
            r_s1_oor      <= (t_cmd'(i_in.cmd) == CMD_STAMP) & cur_cell.oor;
            r_s1_done     <= (t_cmd'(i_in.cmd) == CMD_STAMP) & cur_cell.done;
            r_s1_fwd      <= wr_en & (wr_addr == rd_addr);
            r_s1_fwd_data <= wr_data;
        end
    end

    // tilemap memory
    logic [15:0] mem [MAP_WORDS];
    logic [15:0] r_mem_q;

    always_ff @(posedge i_clk) begin
        if (acc) begin
            r_mem_q <= mem[rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    // stage two: modify, write back, build result
    logic [15:0] old_word;
    logic [3:0]  new_id;
    t_out        res;

    always_comb begin
        old_word = r_s1_fwd ? r_s1_fwd_data : r_mem_q;
        new_id   = r_id_src ? r_fixed_id : r_s1_byte[3:0];
        res      = '0;
        wr_en    = 1'b0;
        wr_addr  = r_s1_addr;
        wr_data  = r_s1_data;
        case (t_cmd'(r_s1_cmd))
            CMD_LOAD: begin
                wr_en         = r_s1_vld;
                res.read_data = r_s1_data;
            end
            CMD_READ: begin
                res.read_data = old_word;
            end
            CMD_STAMP: begin
                res.blob_done    = r_s1_done;
                res.out_of_range = r_s1_oor;
                res.echo_id      = (r_id_src && r_s1_byte != 8'd0) ? r_s1_byte : 8'd0;
                if (!r_s1_oor) begin
                    res.write_addr = r_s1_addr;
                    if (r_s1_byte != 8'd0) begin
                        wr_data       = {new_id, old_word[11:0]};
                        wr_en         = r_s1_vld;
                        res.read_data = wr_data;
                        res.wrote     = 1'b1;
                    end
                end
            end
            default: ;
        endcase
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_res_vld <= 1'b0;
        end else begin
            o_res_vld <= r_s1_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_s1_vld) begin
            o_res <= res;
        end
    end

endmodule
`default_nettype wire
